/* rtl/core/cis_pkg.sv */
`default_nettype none

package cis_pkg;

   // Command codes of the decoded instruction subset.
   localparam logic [4:0] CMD_LDA_IMM = 5'd0;
   localparam logic [4:0] CMD_LDX_IMM = 5'd1;
   localparam logic [4:0] CMD_LDA_ABS = 5'd2;
   localparam logic [4:0] CMD_LDX_ABS = 5'd3;
   localparam logic [4:0] CMD_LDY_ABS = 5'd4;
   localparam logic [4:0] CMD_STA_ABS = 5'd5;
   localparam logic [4:0] CMD_STX_ABS = 5'd6;
   localparam logic [4:0] CMD_STY_ABS = 5'd7;
   localparam logic [4:0] CMD_TAX     = 5'd8;
   localparam logic [4:0] CMD_TAY     = 5'd9;
   localparam logic [4:0] CMD_TXA     = 5'd10;
   localparam logic [4:0] CMD_TYA     = 5'd11;
   localparam logic [4:0] CMD_TSX     = 5'd12;
   localparam logic [4:0] CMD_TXS     = 5'd13;
   localparam logic [4:0] CMD_INX     = 5'd14;
   localparam logic [4:0] CMD_INY     = 5'd15;
   localparam logic [4:0] CMD_BIT_ABS = 5'd16;
   localparam logic [4:0] CMD_JMP_ABS = 5'd17;
   localparam logic [4:0] CMD_BPL     = 5'd18;
   localparam logic [4:0] CMD_SEI     = 5'd19;
   localparam logic [4:0] CMD_CLD     = 5'd20;

   // Status flag masks, bit order N V - B D I Z C.
   localparam logic [7:0] FLAG_N        = 8'h80;
   localparam logic [7:0] FLAG_V        = 8'h40;
   localparam logic [7:0] FLAG_D        = 8'h08;
   localparam logic [7:0] FLAG_I        = 8'h04;
   localparam logic [7:0] FLAG_Z        = 8'h02;
   localparam logic [7:0] BIT_COPY_MASK = 8'hc0;
   localparam logic [7:0] HIGH_ONES     = 8'hff;

   // Cycle counts.
   localparam logic [2:0] CYC_SHORT = 3'd2;
   localparam logic [2:0] CYC_MID   = 3'd3;
   localparam logic [2:0] CYC_LONG  = 3'd4;

   // Architectural register file.
   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  s;
      logic [7:0]  p;
   } cis_state_type;

   // One decoded instruction.
   typedef struct packed {
      logic [4:0]  command;
      logic [15:0] operand;
      logic [7:0]  read_data;
   } cis_req_type;

   // One execution result.
   typedef struct packed {
      logic [15:0] next_pc;
      logic        write_enable;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic [2:0]  cycle_count;
      logic [7:0]  a_value;
      logic [7:0]  x_value;
      logic [7:0]  y_value;
      logic [7:0]  status_value;
      logic [7:0]  stack_value;
   } cis_rsp_type;

endpackage

`default_nettype wire

/* rtl/core/cis_req_if.sv */
`default_nettype none

interface cis_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  command;
   logic [15:0] operand;
   logic [7:0]  read_data;

   modport source (output valid, output command, output operand, output read_data,
                   input ready);
   modport sink (input valid, input command, input operand, input read_data,
                 output ready);
endinterface

`default_nettype wire

/* rtl/core/cis_rsp_if.sv */
`default_nettype none

interface cis_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic        write_enable;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic [2:0]  cycle_count;
   logic [7:0]  a_value;
   logic [7:0]  x_value;
   logic [7:0]  y_value;
   logic [7:0]  status_value;
   logic [7:0]  stack_value;

   modport source (output valid, output next_pc, output write_enable,
                   output write_address, output write_data, output cycle_count,
                   output a_value, output x_value, output y_value,
                   output status_value, output stack_value, input ready);
   modport sink (input valid, input next_pc, input write_enable,
                 input write_address, input write_data, input cycle_count,
                 input a_value, input x_value, input y_value,
                 input status_value, input stack_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/cis_exec.sv */
`default_nettype none

module cis_exec (
   input  wire cis_pkg::cis_state_type state,
   input  wire cis_pkg::cis_req_type   item,
   output cis_pkg::cis_state_type state_next,
   output cis_pkg::cis_rsp_type   result
);
   import cis_pkg::*;

   logic [7:0]  imm;
   logic [15:0] seq_pc;
   logic [15:0] branch_pc;

   // Immediate byte and branch target arithmetic.
   assign imm       = item.operand[7:0];
   assign seq_pc    = state.pc + 16'd2;
   assign branch_pc = seq_pc + {(imm[7] ? HIGH_ONES : 8'h00), imm};

   // Instruction decode and register update.
   always_comb begin
      cis_state_type st;
      logic [15:0]   npc;
      logic [2:0]    cyc;
      logic          we;
      logic [15:0]   waddr;
      logic [7:0]    wdata;
      logic [7:0]    nz_val;
      logic          nz_upd;

      st     = state;
      npc    = state.pc + 16'd1;
      cyc    = CYC_SHORT;
      we     = 1'b0;
      waddr  = 16'd0;
      wdata  = 8'd0;
      nz_val = 8'd0;
      nz_upd = 1'b0;

      case (item.command)
         CMD_LDA_IMM: begin
            st.a = imm; nz_val = imm; nz_upd = 1'b1; npc = seq_pc;
         end
         CMD_LDX_IMM: begin
            st.x = imm; nz_val = imm; nz_upd = 1'b1; npc = seq_pc;
         end
         CMD_LDA_ABS: begin
            st.a = item.read_data; nz_val = item.read_data; nz_upd = 1'b1;
            npc = state.pc + 16'd3; cyc = CYC_LONG;
         end
         CMD_LDX_ABS: begin
            st.x = item.read_data; nz_val = item.read_data; nz_upd = 1'b1;
            npc = state.pc + 16'd3; cyc = CYC_LONG;
         end
         CMD_LDY_ABS: begin
            st.y = item.read_data; nz_val = item.read_data; nz_upd = 1'b1;
            npc = state.pc + 16'd3; cyc = CYC_LONG;
         end
         CMD_STA_ABS: begin
            we = 1'b1; waddr = item.operand; wdata = state.a;
            npc = state.pc + 16'd3; cyc = CYC_LONG;
         end
         CMD_STX_ABS: begin
            we = 1'b1; waddr = item.operand; wdata = state.x;
            npc = state.pc + 16'd3; cyc = CYC_LONG;
         end
         CMD_STY_ABS: begin
            we = 1'b1; waddr = item.operand; wdata = state.y;
            npc = state.pc + 16'd3; cyc = CYC_LONG;
         end
         CMD_TAX: begin
            st.x = state.a; nz_val = state.a; nz_upd = 1'b1;
         end
         CMD_TAY: begin
            st.y = state.a; nz_val = state.a; nz_upd = 1'b1;
         end
         CMD_TXA: begin
            st.a = state.x; nz_val = state.x; nz_upd = 1'b1;
         end
         CMD_TYA: begin
            st.a = state.y; nz_val = state.y; nz_upd = 1'b1;
         end
         CMD_TSX: begin
            st.x = state.s; nz_val = state.s; nz_upd = 1'b1;
         end
         CMD_TXS: begin
            st.s = state.x;
         end
         CMD_INX: begin
            st.x = state.x + 8'd1; nz_val = st.x; nz_upd = 1'b1;
         end
         CMD_INY: begin
            st.y = state.y + 8'd1; nz_val = st.y; nz_upd = 1'b1;
         end
         CMD_BIT_ABS: begin
            st.p = (state.p & ~(FLAG_N | FLAG_V | FLAG_Z))
                   | (item.read_data & BIT_COPY_MASK)
                   | (((state.a & item.read_data) == 8'd0) ? FLAG_Z : 8'd0);
            npc = state.pc + 16'd3; cyc = CYC_LONG;
         end
         CMD_JMP_ABS: begin
            npc = item.operand; cyc = CYC_MID;
         end
         CMD_BPL: begin
            npc = seq_pc;
            if ((state.p & FLAG_N) == 8'd0) begin
               npc = branch_pc;
               cyc = (branch_pc[15:8] != seq_pc[15:8]) ? CYC_LONG : CYC_MID;
            end
         end
         CMD_SEI: begin
            st.p = state.p | FLAG_I;
         end
         CMD_CLD: begin
            st.p = state.p & ~FLAG_D;
         end
         default: begin
         end
      endcase

      // Loads, transfers other than TXS and increments refresh N and Z.
      if (nz_upd) begin
         st.p = (st.p & ~(FLAG_N | FLAG_Z))
                | (nz_val[7] ? FLAG_N : 8'd0)
                | ((nz_val == 8'd0) ? FLAG_Z : 8'd0);
      end

      st.pc = npc;
      state_next           = st;
      result.next_pc       = npc;
      result.write_enable  = we;
      result.write_address = waddr;
      result.write_data    = wdata;
      result.cycle_count   = cyc;
      result.a_value       = st.a;
      result.x_value       = st.x;
      result.y_value       = st.y;
      result.status_value  = st.p;
      result.stack_value   = st.s;
   end

endmodule

`default_nettype wire

/* rtl/core/cpu_instruction_subset_execute_top.sv */
`default_nettype none

// Channel   Direction  Transfer when          Payload
// req_bus   in         valid && ready         command, operand, read_data
// rsp_bus   out        valid && ready         next_pc, write fields, cycle_count, registers
//
// On its req transfer each instruction is loaded into the input register, where
// the execute logic computes its result; when the stage advances, the result
// register is loaded and offers it on rsp. One instruction is accepted every
// cycle while rsp is taken.
// Synchronous reset clears PC, A, X, Y, S and P and empties both registers.
// A stalled result holds the result register; one more item may wait in the
// input register behind it before req ready drops.

module cpu_instruction_subset_execute_top (
   input  wire logic clock,
   input  wire logic reset,
   cis_req_if.sink   req_bus,
   cis_rsp_if.source rsp_bus
);
   import cis_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   cis_req_type   in_item_ff;
   cis_state_type state_ff;
   cis_state_type state_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   cis_rsp_type   out_item_ff;
   cis_rsp_type   exec_result;
   logic          advance;
   logic          req_take;

   // Execute logic between the input and result registers.
   cis_exec u_exec (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .result     (exec_result)
   );

   // Stage advance and handshake.
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command   <= req_bus.command;
         in_item_ff.operand   <= req_bus.operand;
         in_item_ff.read_data <= req_bus.read_data;
      end
      if (advance && in_valid_ff) begin
         out_item_ff <= exec_result;
      end
   end

   // Result channel.
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.next_pc       = out_item_ff.next_pc;
   assign rsp_bus.write_enable  = out_item_ff.write_enable;
   assign rsp_bus.write_address = out_item_ff.write_address;
   assign rsp_bus.write_data    = out_item_ff.write_data;
   assign rsp_bus.cycle_count   = out_item_ff.cycle_count;
   assign rsp_bus.a_value       = out_item_ff.a_value;
   assign rsp_bus.x_value       = out_item_ff.x_value;
   assign rsp_bus.y_value       = out_item_ff.y_value;
   assign rsp_bus.status_value  = out_item_ff.status_value;
   assign rsp_bus.stack_value   = out_item_ff.stack_value;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cis_pkg::*;

   // Cycles without any transfer before the run is declared hung.
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned RANDOM_COUNT = 1100;
   // Cycles still run after the last result has been checked.
   localparam int unsigned DRAIN_CYCLES = 8;

   logic clock;
   logic reset;

   cis_req_if req_bus ();
   cis_rsp_if rsp_bus ();

   cpu_instruction_subset_execute_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Instructions waiting to be sent and results still owed by the block.
   cis_req_type pending_instrs[$];
   cis_rsp_type expected_results[$];

   int unsigned total_instrs;
   int unsigned accepted_count;
   int unsigned mismatch_count;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned quiet_cycles;

   // Register file of the predicted processor.
   logic [15:0] model_pc;
   logic [7:0]  model_a;
   logic [7:0]  model_x;
   logic [7:0]  model_y;
   logic [7:0]  model_s;
   logic [7:0]  model_p;

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // N takes bit 7 of the new value and Z is set when it is zero.
   function automatic logic [7:0] flags_after_load(input logic [7:0] value);
      logic [7:0] flags;
      flags = model_p & ~(FLAG_N | FLAG_Z);
      if (value == 8'h00) begin
         flags = flags | FLAG_Z;
      end
      if ((value & FLAG_N) != 8'h00) begin
         flags = flags | FLAG_N;
      end
      return flags;
   endfunction

   // Executes one instruction on the predicted register file and returns its result.
   function automatic cis_rsp_type execute_instruction(input cis_req_type instr);
      cis_rsp_type res;
      logic [7:0]  imm;
      logic [15:0] seq_pc;
      logic [15:0] target;
      imm = instr.operand[7:0];
      res = '0;
      res.next_pc = model_pc + 16'd1;
      res.cycle_count = CYC_SHORT;
      case (instr.command)
         CMD_LDA_IMM: begin
            model_p = flags_after_load(imm);
            model_a = imm;
            res.next_pc = model_pc + 16'd2;
         end
         CMD_LDX_IMM: begin
            model_p = flags_after_load(imm);
            model_x = imm;
            res.next_pc = model_pc + 16'd2;
         end
         CMD_LDA_ABS, CMD_LDX_ABS, CMD_LDY_ABS: begin
            model_p = flags_after_load(instr.read_data);
            if (instr.command == CMD_LDA_ABS) begin
               model_a = instr.read_data;
            end else if (instr.command == CMD_LDX_ABS) begin
               model_x = instr.read_data;
            end else begin
               model_y = instr.read_data;
            end
            res.next_pc = model_pc + 16'd3;
            res.cycle_count = CYC_LONG;
         end
         CMD_STA_ABS, CMD_STX_ABS, CMD_STY_ABS: begin
            res.write_enable = 1'b1;
            res.write_address = instr.operand;
            if (instr.command == CMD_STA_ABS) begin
               res.write_data = model_a;
            end else if (instr.command == CMD_STX_ABS) begin
               res.write_data = model_x;
            end else begin
               res.write_data = model_y;
            end
            res.next_pc = model_pc + 16'd3;
            res.cycle_count = CYC_LONG;
         end
         CMD_TAX: begin
            model_p = flags_after_load(model_a);
            model_x = model_a;
         end
         CMD_TAY: begin
            model_p = flags_after_load(model_a);
            model_y = model_a;
         end
         CMD_TXA: begin
            model_p = flags_after_load(model_x);
            model_a = model_x;
         end
         CMD_TYA: begin
            model_p = flags_after_load(model_y);
            model_a = model_y;
         end
         CMD_TSX: begin
            model_p = flags_after_load(model_s);
            model_x = model_s;
         end
         CMD_TXS: begin
            model_s = model_x;
         end
         CMD_INX: begin
            model_x = model_x + 8'd1;
            model_p = flags_after_load(model_x);
         end
         CMD_INY: begin
            model_y = model_y + 8'd1;
            model_p = flags_after_load(model_y);
         end
         CMD_BIT_ABS: begin
            model_p = (model_p & ~(FLAG_N | FLAG_V | FLAG_Z))
                      | (instr.read_data & BIT_COPY_MASK);
            if ((model_a & instr.read_data) == 8'h00) begin
               model_p = model_p | FLAG_Z;
            end
            res.next_pc = model_pc + 16'd3;
            res.cycle_count = CYC_LONG;
         end
         CMD_JMP_ABS: begin
            res.next_pc = instr.operand;
            res.cycle_count = CYC_MID;
         end
         CMD_BPL: begin
            seq_pc = model_pc + 16'd2;
            res.next_pc = seq_pc;
            if ((model_p & FLAG_N) == 8'h00) begin
               target = seq_pc + {{8{imm[7]}}, imm};
               res.next_pc = target;
               res.cycle_count = (target[15:8] != seq_pc[15:8]) ? CYC_LONG : CYC_MID;
            end
         end
         CMD_SEI: begin
            model_p = model_p | FLAG_I;
         end
         CMD_CLD: begin
            model_p = model_p & ~FLAG_D;
         end
         default: begin
            // Unused codes only advance the program counter.
         end
      endcase
      model_pc = res.next_pc;
      res.a_value = model_a;
      res.x_value = model_x;
      res.y_value = model_y;
      res.status_value = model_p;
      res.stack_value = model_s;
      return res;
   endfunction

   task automatic queue_instr(input logic [4:0] command, input logic [15:0] operand,
                              input logic [7:0] read_data);
      cis_req_type instr;
      instr.command = command;
      instr.operand = operand;
      instr.read_data = read_data;
      pending_instrs.push_back(instr);
   endtask

   // Mostly random values, with the field extremes mixed in.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h00ff;
         3: return 16'hff00;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic check_field(input string field_name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field_name, want, got);
         mismatch_count++;
      end
   endtask

   // Idle rates move through three phases as the run progresses.
   always_comb begin
      if (accepted_count < total_instrs / 3) begin
         sender_idle_pct = 27;
         receiver_idle_pct = 54;
      end else if (accepted_count < (2 * total_instrs) / 3) begin
         sender_idle_pct = 54;
         receiver_idle_pct = 27;
      end else begin
         sender_idle_pct = 0;
         receiver_idle_pct = 0;
      end
   end

   // Request driver: predicts each transfer and presents the next instruction.
   always @(posedge clock) begin : instr_driver
      cis_req_type seen_instr;
      cis_req_type next_instr;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.command <= '0;
         req_bus.operand <= '0;
         req_bus.read_data <= '0;
         model_pc = '0;
         model_a = '0;
         model_x = '0;
         model_y = '0;
         model_s = '0;
         model_p = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen_instr.command = req_bus.command;
            seen_instr.operand = req_bus.operand;
            seen_instr.read_data = req_bus.read_data;
            expected_results.push_back(execute_instruction(seen_instr));
            accepted_count <= accepted_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_instr = pending_instrs.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.command <= next_instr.command;
               req_bus.operand <= next_instr.operand;
               req_bus.read_data <= next_instr.read_data;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each transfer with the oldest prediction.
   always @(posedge clock) begin : result_monitor
      cis_rsp_type got;
      cis_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.next_pc = rsp_bus.next_pc;
            got.write_enable = rsp_bus.write_enable;
            got.write_address = rsp_bus.write_address;
            got.write_data = rsp_bus.write_data;
            got.cycle_count = rsp_bus.cycle_count;
            got.a_value = rsp_bus.a_value;
            got.x_value = rsp_bus.x_value;
            got.y_value = rsp_bus.y_value;
            got.status_value = rsp_bus.status_value;
            got.stack_value = rsp_bus.stack_value;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, got);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("write_enable", 16'(want.write_enable),
                           16'(got.write_enable));
               check_field("write_address", want.write_address, got.write_address);
               check_field("write_data", 16'(want.write_data), 16'(got.write_data));
               check_field("cycle_count", 16'(want.cycle_count), 16'(got.cycle_count));
               check_field("a_value", 16'(want.a_value), 16'(got.a_value));
               check_field("x_value", 16'(want.x_value), 16'(got.x_value));
               check_field("y_value", 16'(want.y_value), 16'(got.y_value));
               check_field("status_value", 16'(want.status_value),
                           16'(got.status_value));
               check_field("stack_value", 16'(want.stack_value), 16'(got.stack_value));
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [4:0] command;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.operand = '0;
      req_bus.read_data = '0;
      rsp_bus.ready = 1'b0;
      accepted_count = 0;
      mismatch_count = 0;
      quiet_cycles = 0;

      // Directed part: flag edges, every operation, branch and wrap cases.
      queue_instr(CMD_LDA_IMM, 16'hff00, 8'hff);      // zero sets Z
      queue_instr(CMD_LDA_IMM, 16'h0080, 8'h00);      // bit 7 sets N
      queue_instr(CMD_BPL, 16'h0010, 8'h00);          // N set, branch not taken
      queue_instr(CMD_LDX_IMM, 16'h00ff, 8'h00);
      queue_instr(CMD_INX, 16'hffff, 8'hff);          // X wraps to zero
      queue_instr(CMD_LDA_ABS, 16'hffff, 8'h7f);
      queue_instr(CMD_LDX_ABS, 16'h0000, 8'h00);
      queue_instr(CMD_LDY_ABS, 16'h8000, 8'hff);
      queue_instr(CMD_INY, 16'h0000, 8'h00);          // Y wraps to zero
      queue_instr(CMD_STA_ABS, 16'hffff, 8'hff);
      queue_instr(CMD_STX_ABS, 16'h0000, 8'h00);
      queue_instr(CMD_STY_ABS, 16'ha5a5, 8'h5a);
      queue_instr(CMD_TAX, 16'h1234, 8'h00);
      queue_instr(CMD_TAY, 16'h0000, 8'h00);
      queue_instr(CMD_LDX_IMM, 16'h0080, 8'h00);
      queue_instr(CMD_TXS, 16'h0000, 8'h00);          // stack gets 0x80, flags kept
      queue_instr(CMD_TXA, 16'h0000, 8'h00);
      queue_instr(CMD_TYA, 16'h0000, 8'h00);
      queue_instr(CMD_TSX, 16'h0000, 8'h00);
      queue_instr(CMD_BIT_ABS, 16'h4000, 8'hc0);      // N and V copied
      queue_instr(CMD_BIT_ABS, 16'h4001, 8'h00);      // no common bits sets Z
      queue_instr(CMD_JMP_ABS, 16'h00f0, 8'h00);
      queue_instr(CMD_BPL, 16'h0020, 8'h00);          // taken forward across a page
      queue_instr(CMD_BPL, 16'h0080, 8'h00);          // taken backward across a page
      queue_instr(CMD_BPL, 16'h0000, 8'h00);          // taken within the page
      queue_instr(CMD_JMP_ABS, 16'hfffe, 8'h00);
      queue_instr(CMD_BPL, 16'h0005, 8'h00);          // target wraps past the top
      queue_instr(CMD_SEI, 16'h0000, 8'h00);
      queue_instr(CMD_CLD, 16'h0000, 8'h00);
      queue_instr(5'd31, 16'hffff, 8'hff);            // unused code acts as a no-op

      // Random part: mostly valid commands, a few unused codes.
      repeat (RANDOM_COUNT) begin
         if ($urandom_range(0, 99) < 6) begin
            command = 5'($urandom_range(21, 31));
         end else begin
            command = 5'($urandom_range(0, 20));
         end
         queue_instr(command, pick_word(), 8'(pick_word()));
      end
      total_instrs = pending_instrs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_instrs.size() != 0 || req_bus.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
